// ===== hw/rtl/htt_pkg.sv =====
// htt_pkg: shared types and codes for the handle translation table
// used by htt_mem and handle_translation_table; no dependencies
package htt_pkg;

  localparam int HANDLE_W      = 32;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int TOTAL_W       = 9;
  localparam int DEPTH_DEFAULT = 256;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] remote_key;
    logic [HANDLE_W-1:0] local_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_local;
    logic [TOTAL_W-1:0]  entry_total;
  } out_word_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] key;
    logic [HANDLE_W-1:0] value;
  } entry_t;

endpackage

// ===== hw/rtl/htt_mem.sv =====
// htt_mem: table storage, one write port and one registered read port
// depends on htt_pkg for the entry type
module htt_mem #(
  parameter int TABLE_DEPTH = htt_pkg::DEPTH_DEFAULT,
  localparam int AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  htt_pkg::entry_t  wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output htt_pkg::entry_t  rd_data
);

  htt_pkg::entry_t mem [TABLE_DEPTH];
  htt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/handle_translation_table.sv =====
// Handle translation table: an ordered list of up to TABLE_DEPTH pairs of 32-bit remote
// and local handles, searched by one shared 32-bit key comparator that walks the table
// memory one entry per cycle. Add and clear keep busy low, and the result appears on
// the next cycle. Find reads the entries in order from entry 0 and answers at the first
// match, or after the last entry when there is none. Remove runs the same scan, then
// moves each entry above the match down one place to close the gap. The walk rate is
// set by the single read port of the table memory. busy is high while a find or remove
// is in progress. Each result is shown for exactly one cycle with out_valid and cannot
// be held off, so the receiver must take it.
// depends on htt_pkg and htt_mem
module handle_translation_table #(
  parameter int TABLE_DEPTH = htt_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  htt_pkg::in_word_t  in_word,
  output logic               busy,
  output logic               out_valid,
  output htt_pkg::out_word_t out_word
);

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [htt_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [htt_pkg::HANDLE_W-1:0]   key_r, key_nxt;
  logic [AddrW-1:0]               idx_r, idx_nxt;
  logic [CntW-1:0]                count_r, count_nxt;
  logic                           out_valid_r, out_valid_nxt;
  htt_pkg::out_word_t             out_word_r, out_word_nxt;

  logic [CntW-1:0]                idx_inc;
  logic                           hit;
  logic                           mem_we;
  logic [AddrW-1:0]               mem_waddr;
  htt_pkg::entry_t                mem_wdata;
  logic [AddrW-1:0]               mem_raddr;
  htt_pkg::entry_t                mem_rdata;

  htt_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign idx_inc = CntW'(idx_r) + CntW'(1);
  // the shared comparator
  assign hit     = (mem_rdata.key == key_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_word.command;
          key_nxt = in_word.remote_key;
          out_word_nxt.found_local = '0;
          case (in_word.command)
            htt_pkg::CMD_FIND, htt_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_word_nxt.status = htt_pkg::ST_NOTFOUND;
                out_word_nxt.entry_total = htt_pkg::TOTAL_W'(count_r);
              end else begin
                // entry 0 is read this cycle
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            htt_pkg::CMD_ADD: begin
              out_valid_nxt = 1'b1;
              if (count_r == DepthCnt) begin
                out_word_nxt.status = htt_pkg::ST_FULL;
                out_word_nxt.entry_total = htt_pkg::TOTAL_W'(count_r);
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = count_r[AddrW-1:0];
                mem_wdata.key   = in_word.remote_key;
                mem_wdata.value = in_word.local_value;
                count_nxt       = count_r + CntW'(1);
                out_word_nxt.status = htt_pkg::ST_OK;
                out_word_nxt.entry_total = htt_pkg::TOTAL_W'(count_nxt);
              end
            end
            default: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_word_nxt.status = htt_pkg::ST_OK;
              out_word_nxt.entry_total = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read data holds entry idx_r
        if (hit) begin
          if (cmd_r == htt_pkg::CMD_FIND) begin
            out_valid_nxt = 1'b1;
            out_word_nxt.status = htt_pkg::ST_OK;
            out_word_nxt.found_local = mem_rdata.value;
            out_word_nxt.entry_total = htt_pkg::TOTAL_W'(count_r);
            state_nxt = ST_IDLE;
          end else begin
            // fetch the entry above the match for the shift
            mem_raddr = idx_inc[AddrW-1:0];
            state_nxt = ST_SHIFT;
          end
        end else if (idx_inc == count_r) begin
          out_valid_nxt = 1'b1;
          out_word_nxt.status = htt_pkg::ST_NOTFOUND;
          out_word_nxt.found_local = '0;
          out_word_nxt.entry_total = htt_pkg::TOTAL_W'(count_r);
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_inc[AddrW-1:0];
          mem_raddr = idx_inc[AddrW-1:0];
        end
      end

      ST_SHIFT: begin
        // read data holds entry idx_r + 1
        if (idx_inc < count_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = mem_rdata;
          idx_nxt   = idx_inc[AddrW-1:0];
          mem_raddr = idx_inc[AddrW-1:0] + AddrW'(1);
        end else begin
          count_nxt     = count_r - CntW'(1);
          out_valid_nxt = 1'b1;
          out_word_nxt.status = htt_pkg::ST_OK;
          out_word_nxt.found_local = '0;
          out_word_nxt.entry_total = htt_pkg::TOTAL_W'(count_nxt);
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DepthCnt)
    else $error("entry count above table depth");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.command == htt_pkg::CMD_CLEAR)
    |=> (out_valid_r && out_word_r.entry_total == '0 && count_r == '0))
    else $error("clear did not empty the table");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SHIFT
                || (state_r == ST_IDLE && start && in_word.command == htt_pkg::CMD_ADD)))
    else $error("table written outside add or shift");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == htt_pkg::ST_FULL) |-> count_r == DepthCnt)
    else $error("full reported below depth");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (count_r != '0 && idx_inc <= count_r))
    else $error("shift outside valid entries");

endmodule
